FILE: rtl/pse_pkg.sv
// Shared codes, defaults and controller/datapath interface types for the postfix evaluator.
package pse_pkg;

    // Default sizing
    localparam int PSE_STACK_DEPTH = 16;
    localparam int PSE_VALUE_WIDTH = 32;

    // Token opcodes (codes above OP_DIV other than OP_CLEAR are unknown operators)
    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_SUB   = 3'd2;
    localparam logic [2:0] OP_MUL   = 3'd3;
    localparam logic [2:0] OP_DIV   = 3'd4;
    localparam logic [2:0] OP_CLEAR = 3'd5;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_DIVZERO   = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;
    localparam logic [2:0] ST_HALTED    = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;     // empty the stack
        logic push;      // push the incoming operand
        logic wr_alu;    // replace the top two entries with the add/sub result
        logic sub;       // add/sub select: subtract
        logic start_md;  // launch the multiply/divide unit
        logic md_div;    // multiply/divide select: divide
        logic wr_md;     // replace the top two entries with the mul/div result
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic full;      // no room for a push
        logic lt2;       // fewer than two entries held
        logic top_zero;  // top entry is zero
        logic md_done;   // multiply/divide result ready
    } t_dp_stat;

endpackage

FILE: rtl/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pse_muldiv.sv
// Bit-serial multiply (shift-add) and signed truncating divide (restoring) unit.
module pse_muldiv #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_div,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_done,
    output logic [W-1:0] o_result
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic          r_div;
    logic          r_neg;
    logic [W-1:0]  r_acc;  // product accumulator or partial remainder
    logic [W-1:0]  r_x;    // multiplier (shifts right) or dividend/quotient (shifts left)
    logic [W-1:0]  r_y;    // multiplicand (shifts left) or divisor magnitude

    logic [W-1:0]  n_acc;
    logic [W-1:0]  n_x;
    logic [W-1:0]  n_y;
    logic [W:0]    rem_sh;
    logic [W:0]    diff;
    logic [W-1:0]  a_abs;
    logic [W-1:0]  b_abs;

    // Operand magnitudes for the divide
    assign a_abs = i_a[W-1] ? (W'(0) - i_a) : i_a;
    assign b_abs = i_b[W-1] ? (W'(0) - i_b) : i_b;

    // One iteration step
    always_comb begin
        rem_sh = {r_acc, r_x[W-1]};
        diff   = rem_sh - {1'b0, r_y};
        if (r_div) begin
            n_y = r_y;
            if (!diff[W]) begin
                n_acc = diff[W-1:0];
                n_x   = {r_x[W-2:0], 1'b1};
            end else begin
                n_acc = rem_sh[W-1:0];
                n_x   = {r_x[W-2:0], 1'b0};
            end
        end else begin
            n_acc = r_x[0] ? (r_acc + r_y) : r_acc;
            n_x   = r_x >> 1;
            n_y   = r_y << 1;
        end
    end

    // Control: W steps, then a one-cycle done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and working registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_div;
            r_neg <= i_a[W-1] ^ i_b[W-1];
            r_acc <= '0;
            if (i_div) begin
                r_x <= a_abs;
                r_y <= b_abs;
            end else begin
                r_x <= i_b;
                r_y <= i_a;
            end
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_x   <= n_x;
            r_y   <= n_y;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_div ? (r_neg ? (W'(0) - r_x) : r_x) : r_acc;

endmodule

FILE: rtl/pse_ctrl.sv
// Token sequencer: checks each token, issues datapath commands and registers the status.
module pse_ctrl
    import pse_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic [2:0] i_op,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_valid,
    output logic [2:0] o_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_op, n_op;
    logic       r_err, n_err;
    logic       r_valid, n_valid;
    logic [2:0] r_status, n_status;
    t_dp_cmd    cmd;

    // Next state, commands and result status
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_err    = r_err;
        n_valid  = 1'b0;
        n_status = r_status;
        cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    if (i_op == OP_CLEAR) begin
                        cmd.clear = 1'b1;
                        n_err     = 1'b0;
                    end else if (r_err) begin
                        n_status = ST_HALTED;
                    end else if (i_op == OP_PUSH) begin
                        if (i_stat.full) begin
                            n_status = ST_OVERFLOW;
                            n_err    = 1'b1;
                        end else begin
                            cmd.push = 1'b1;
                        end
                    end else if (i_stat.lt2) begin
                        n_status = ST_UNDERFLOW;
                        n_err    = 1'b1;
                    end else if (i_op > OP_DIV) begin
                        n_status = ST_UNKNOWN;
                        n_err    = 1'b1;
                    end else if (i_op == OP_DIV && i_stat.top_zero) begin
                        n_status = ST_DIVZERO;
                        n_err    = 1'b1;
                    end else begin
                        // left operand is being read; result comes later
                        n_valid = 1'b0;
                        n_op    = i_op;
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (r_op == OP_ADD || r_op == OP_SUB) begin
                    cmd.wr_alu = 1'b1;
                    cmd.sub    = (r_op == OP_SUB);
                    n_valid    = 1'b1;
                    n_status   = ST_OK;
                    n_state    = S_IDLE;
                end else begin
                    cmd.start_md = 1'b1;
                    cmd.md_div   = (r_op == OP_DIV);
                    n_state      = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_stat.md_done) begin
                    cmd.wr_md = 1'b1;
                    n_valid   = 1'b1;
                    n_status  = ST_OK;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_PUSH;
            r_err    <= 1'b0;
            r_valid  <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_err    <= n_err;
            r_valid  <= n_valid;
            r_status <= n_status;
        end
    end

    assign o_cmd    = cmd;
    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;

endmodule

FILE: rtl/pse_dp.sv
// Stack datapath: stack RAM, top-of-stack and depth registers, add/sub and mul/div unit.
module pse_dp
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = PSE_STACK_DEPTH,
    parameter int VALUE_WIDTH = PSE_VALUE_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_dp_cmd                          i_cmd,
    input  logic signed [31:0]               i_operand,
    output t_dp_stat                         o_stat,
    output logic signed [31:0]               o_top_value,
    output logic [$clog2(STACK_DEPTH+1)-1:0] o_stack_depth
);

    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int W  = VALUE_WIDTH;

    logic [PW-1:0]      r_sp;
    logic [W-1:0]       r_top;
    logic [PW-1:0]      sp_m2;
    logic [AW-1:0]      waddr;
    logic [W-1:0]       wdata;
    logic               we;
    logic [W-1:0]       left;
    logic [W-1:0]       alu;
    logic [W-1:0]       md_result;
    logic               md_done;
    logic signed [63:0] opnd_ext;
    logic signed [63:0] top_ext;

    // Operand sign-extended, then kept at the stack width
    assign opnd_ext = 64'(i_operand);
    assign sp_m2    = r_sp - PW'(2);

    // Add/sub on the left entry (from RAM) and the top register
    assign alu = i_cmd.sub ? (left - r_top) : (left + r_top);

    // Stack write: push at the depth, results below the top
    assign we    = i_cmd.push | i_cmd.wr_alu | i_cmd.wr_md;
    assign waddr = i_cmd.push ? r_sp[AW-1:0] : sp_m2[AW-1:0];
    assign wdata = i_cmd.push ? opnd_ext[W-1:0] : (i_cmd.wr_alu ? alu : md_result);

    pse_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (sp_m2[AW-1:0]),
        .o_rdata (left)
    );

    pse_muldiv #(
        .W (W)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.start_md),
        .i_div    (i_cmd.md_div),
        .i_a      (left),
        .i_b      (r_top),
        .o_done   (md_done),
        .o_result (md_result)
    );

    // Depth counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_cmd.clear) begin
            r_sp <= '0;
        end else if (i_cmd.push) begin
            r_sp <= r_sp + PW'(1);
        end else if (i_cmd.wr_alu || i_cmd.wr_md) begin
            r_sp <= r_sp - PW'(1);
        end
    end

    // Copy of the top entry
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_top <= wdata;
        end
    end

    // Status to the controller
    assign o_stat.full     = (r_sp == PW'(STACK_DEPTH));
    assign o_stat.lt2      = (r_sp < PW'(2));
    assign o_stat.top_zero = (r_top == '0);
    assign o_stat.md_done  = md_done;

    // Result fields
    assign top_ext       = 64'(signed'(r_top));
    assign o_top_value   = (r_sp == '0) ? 32'sd0 : top_ext[31:0];
    assign o_stack_depth = r_sp;

endmodule

FILE: rtl/postfix_stack_evaluator.sv
// Top level of the postfix expression evaluator: controller plus stack datapath.
//
//  channel   direction  transfer when          payload
//  token     in         start && !busy         i_op, i_operand
//  result    out        o_valid (one cycle)    o_status, o_top_value, o_stack_depth
//
// Push, clear and refused tokens: the result strobes the cycle after the transfer and the
// next token can be taken in that same cycle.
// Add and subtract: S_EXEC waits for the registered read of the left entry from stack RAM.
// Multiply and divide: S_EXEC, then S_WAIT until the bit-serial unit signals done.
// Reset is synchronous and active low; it empties the stack and clears the error.
// busy is high while a token is in work; the result side cannot stall.
module postfix_stack_evaluator
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = PSE_STACK_DEPTH,
    parameter int VALUE_WIDTH = PSE_VALUE_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [2:0]                       i_op,
    input  logic signed [31:0]               i_operand,
    output logic                             o_valid,
    output logic [2:0]                       o_status,
    output logic signed [31:0]               o_top_value,
    output logic [$clog2(STACK_DEPTH+1)-1:0] o_stack_depth
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    pse_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_op),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid),
        .o_status (o_status)
    );

    pse_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_operand     (i_operand),
        .o_stat        (stat),
        .o_top_value   (o_top_value),
        .o_stack_depth (o_stack_depth)
    );

    // A result never shows while a token is still in work
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // Depth stays within the stack
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stack_depth <= ($clog2(STACK_DEPTH+1))'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    // A clear answers next cycle with ok and an empty stack
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == OP_CLEAR) |=>
            (o_valid && o_status == ST_OK && o_stack_depth == '0))
        else $error("clear did not empty the stack");

    // A refused token leaves the depth unchanged
    a_err_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_stack_depth == $past(o_stack_depth)))
        else $error("depth changed on an error");

endmodule
